// ----- rtl/qsort_pkg.sv -----
// Shared types and constants for the quicksort engine.
`timescale 1ns / 1ps
package qsort_pkg;

  localparam int QS_DEPTH = 64;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic [STAT_W-1:0]        compare_count;
    logic [STAT_W-1:0]        swap_count;
    logic                     overflow;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_OUTER,
    ST_SCANI,
    ST_SCANJ,
    ST_SWAP2,
    ST_PUSHR,
    ST_PUSHL,
    ST_EFETCH,
    ST_EOUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_DROP,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_OUTER,
    OP_I_STEP,
    OP_I_DONE,
    OP_J_STEP,
    OP_J_SWAP,
    OP_SWAP2,
    OP_PUSH_R,
    OP_PUSH_L,
    OP_EMIT_FETCH,
    OP_EMIT_HOLD,
    OP_EMIT_LOAD,
    OP_EMIT_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic sp_zero;
    logic i_le_j;
    logic i_adv;
    logic j_adv;
    logic push_r_ok;
    logic push_l_ok;
    logic k_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/qsort_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module qsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/qsort_ctrl.sv -----
// Sequencer for load, partition and emit phases of the quicksort engine.
`timescale 1ns / 1ps
module qsort_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output qsort_pkg::dp_cmd_t cmd_o,
  input  qsort_pkg::dp_stat_t stat_i
);
  import qsort_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = stat_i.full ? OP_DROP : OP_STORE;
          if (in_last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = ST_POP;
      end
      ST_POP: begin
        if (stat_i.sp_zero) begin
          state_d = ST_EFETCH;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.op = OP_RANGE;
        state_d  = ST_PIVOT;
      end
      ST_PIVOT: begin
        cmd_o.op = OP_PIVOT;
        state_d  = ST_OUTER;
      end
      ST_OUTER: begin
        if (stat_i.i_le_j) begin
          cmd_o.op = OP_OUTER;
          state_d  = ST_SCANI;
        end else begin
          state_d = ST_PUSHR;
        end
      end
      ST_SCANI: begin
        if (stat_i.i_adv) begin
          cmd_o.op = OP_I_STEP;
        end else begin
          cmd_o.op = OP_I_DONE;
          state_d  = ST_SCANJ;
        end
      end
      ST_SCANJ: begin
        if (stat_i.j_adv) begin
          cmd_o.op = OP_J_STEP;
        end else if (stat_i.i_le_j) begin
          cmd_o.op = OP_J_SWAP;
          state_d  = ST_SWAP2;
        end else begin
          state_d = ST_OUTER;
        end
      end
      ST_SWAP2: begin
        cmd_o.op = OP_SWAP2;
        state_d  = ST_OUTER;
      end
      ST_PUSHR: begin
        if (stat_i.push_r_ok) begin
          cmd_o.op = OP_PUSH_R;
        end
        state_d = ST_PUSHL;
      end
      ST_PUSHL: begin
        if (stat_i.push_l_ok) begin
          cmd_o.op = OP_PUSH_L;
        end
        state_d = ST_POP;
      end
      ST_EFETCH: begin
        cmd_o.op = OP_EMIT_FETCH;
        state_d  = ST_EOUT;
      end
      ST_EOUT: begin
        if (!stat_i.out_free) begin
          cmd_o.op = OP_EMIT_HOLD;
        end else if (stat_i.k_last) begin
          cmd_o.op = OP_EMIT_END;
          state_d  = ST_LOAD;
        end else begin
          cmd_o.op = OP_EMIT_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- rtl/qsort_dp.sv -----
// Datapath: element store, range stack, scan indices, counters and output register.
`timescale 1ns / 1ps
module qsort_dp #(
  parameter int DEPTH = qsort_pkg::QS_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qsort_pkg::in_req_t  in_req_i,
  input  qsort_pkg::dp_cmd_t  cmd_i,
  output qsort_pkg::dp_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qsort_pkg::out_rsp_t out_rsp_o
);
  import qsort_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IW    = IDX_W + 2;  // signed scan index, spans -1 .. DEPTH
  localparam int SK_W  = 2 * IDX_W;

  // control state
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              dropped_q, dropped_d;
  logic [CNT_W-1:0]  sp_q, sp_d;
  logic [STAT_W-1:0] cmp_q, cmp_d;
  logic [STAT_W-1:0] swp_q, swp_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic signed [IW-1:0]     i_q, i_d, j_q, j_d;
  logic [IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic signed [DATA_W-1:0] pivot_q, pivot_d;
  logic [DATA_W-1:0]        ai_q, ai_d;
  out_rsp_t                 out_q, out_d;

  // memories
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr, st_raddr;
  logic [DATA_W-1:0] st_wdata, st_rdata;
  logic              sk_we;
  logic [IDX_W-1:0]  sk_waddr, sk_raddr;
  logic [SK_W-1:0]   sk_wdata, sk_rdata;

  logic signed [IW-1:0]     n_m1, lo_ext, hi_ext;
  logic [CNT_W-1:0]         fill_m1, sp_m1;
  logic [IDX_W:0]           mid_sum;
  logic [IDX_W-1:0]         rd_lo, rd_hi;
  logic signed [DATA_W-1:0] elem;
  logic                     sp_room, out_free, cmp_inc, swp_inc;

  assign fill_m1 = fill_q - CNT_W'(1);
  assign sp_m1   = sp_q - CNT_W'(1);
  assign n_m1    = $signed(IW'(fill_q)) - $signed(IW'(1));
  assign lo_ext  = $signed(IW'(lo_q));
  assign hi_ext  = $signed(IW'(hi_q));
  assign rd_lo   = sk_rdata[SK_W-1:IDX_W];
  assign rd_hi   = sk_rdata[IDX_W-1:0];
  assign mid_sum = {1'b0, rd_lo} + {1'b0, rd_hi};
  assign elem    = $signed(st_rdata);
  assign sp_room = sp_q < CNT_W'(DEPTH);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.full      = fill_q == CNT_W'(DEPTH);
  assign stat_o.sp_zero   = sp_q == '0;
  assign stat_o.i_le_j    = i_q <= j_q;
  assign stat_o.i_adv     = (i_q < n_m1) && (elem < pivot_q);
  assign stat_o.j_adv     = (j_q > $signed(IW'(0))) && (elem > pivot_q);
  assign stat_o.push_r_ok = (hi_ext > i_q) && sp_room;
  assign stat_o.push_l_ok = (lo_ext < j_q) && sp_room;
  assign stat_o.k_last    = (CNT_W'(k_q) + CNT_W'(1)) == fill_q;
  assign stat_o.out_free  = out_free;

  always_comb begin
    fill_d      = fill_q;
    dropped_d   = dropped_q;
    sp_d        = sp_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pivot_d     = pivot_q;
    ai_d        = ai_q;
    out_d       = out_q;
    cmp_inc     = 1'b0;
    swp_inc     = 1'b0;
    st_we       = 1'b0;
    st_waddr    = i_q[IDX_W-1:0];
    st_wdata    = st_rdata;
    st_raddr    = i_q[IDX_W-1:0];
    sk_we       = 1'b0;
    sk_waddr    = sp_q[IDX_W-1:0];
    sk_wdata    = {i_q[IDX_W-1:0], hi_q};
    sk_raddr    = sp_m1[IDX_W-1:0];
    out_valid_d = out_valid_q && !out_ready_i;

    cmp_d = cmp_q;
    swp_d = swp_q;

    case (cmd_i.op)
      OP_STORE: begin
        st_we    = 1'b1;
        st_waddr = fill_q[IDX_W-1:0];
        st_wdata = in_req_i.value;
        fill_d   = fill_q + CNT_W'(1);
      end
      OP_DROP: begin
        dropped_d = 1'b1;
      end
      OP_INIT: begin
        sk_we    = 1'b1;
        sk_waddr = '0;
        sk_wdata = {{IDX_W{1'b0}}, fill_m1[IDX_W-1:0]};
        sp_d     = CNT_W'(1);
        cmp_d    = '0;
        swp_d    = '0;
      end
      OP_POP: begin
        sp_d = sp_m1;
      end
      OP_RANGE: begin
        lo_d     = rd_lo;
        hi_d     = rd_hi;
        i_d      = $signed(IW'(rd_lo));
        j_d      = $signed(IW'(rd_hi));
        st_raddr = mid_sum[IDX_W:1];
      end
      OP_PIVOT: begin
        pivot_d = elem;
      end
      OP_OUTER: begin
        cmp_inc  = 1'b1;
        st_raddr = i_q[IDX_W-1:0];
      end
      OP_I_STEP: begin
        i_d      = i_q + IW'(1);
        cmp_inc  = 1'b1;
        st_raddr = i_d[IDX_W-1:0];
      end
      OP_I_DONE: begin
        ai_d     = st_rdata;
        st_raddr = j_q[IDX_W-1:0];
      end
      OP_J_STEP: begin
        j_d      = j_q - IW'(1);
        cmp_inc  = 1'b1;
        st_raddr = j_d[IDX_W-1:0];
      end
      OP_J_SWAP: begin
        // a[i] takes a[j]; a[j] takes the saved a[i] next cycle
        st_we    = 1'b1;
        st_waddr = i_q[IDX_W-1:0];
        st_wdata = st_rdata;
      end
      OP_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = j_q[IDX_W-1:0];
        st_wdata = ai_q;
        swp_inc  = 1'b1;
        cmp_inc  = 1'b1;
        i_d      = i_q + IW'(1);
        j_d      = j_q - IW'(1);
      end
      OP_PUSH_R: begin
        sk_we    = 1'b1;
        sk_wdata = {i_q[IDX_W-1:0], hi_q};
        sp_d     = sp_q + CNT_W'(1);
      end
      OP_PUSH_L: begin
        sk_we    = 1'b1;
        sk_wdata = {lo_q, j_q[IDX_W-1:0]};
        sp_d     = sp_q + CNT_W'(1);
      end
      OP_EMIT_FETCH: begin
        k_d      = '0;
        st_raddr = '0;
      end
      OP_EMIT_HOLD: begin
        st_raddr = k_q;
      end
      OP_EMIT_LOAD, OP_EMIT_END: begin
        out_valid_d         = 1'b1;
        out_d.sorted_value  = elem;
        out_d.last_out      = cmd_i.op == OP_EMIT_END;
        out_d.compare_count = cmp_q;
        out_d.swap_count    = swp_q;
        out_d.overflow      = dropped_q;
        if (cmd_i.op == OP_EMIT_END) begin
          fill_d    = '0;
          dropped_d = 1'b0;
          st_raddr  = k_q;
        end else begin
          k_d      = k_q + IDX_W'(1);
          st_raddr = k_d;
        end
      end
      default: begin
      end
    endcase

    // saturating event counters
    if (cmp_inc && (cmp_q != '1)) begin
      cmp_d = cmp_q + STAT_W'(1);
    end
    if (swp_inc && (swp_q != '1)) begin
      swp_d = swp_q + STAT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      cmp_q       <= '0;
      swp_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      dropped_q   <= dropped_d;
      sp_q        <= sp_d;
      cmp_q       <= cmp_d;
      swp_q       <= swp_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    pivot_q <= pivot_d;
    ai_q    <= ai_d;
    out_q   <= out_d;
  end

  qsort_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  qsort_ram #(
    .WIDTH(SK_W),
    .DEPTH(DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .raddr_i(sk_raddr),
    .rdata_o(sk_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ----- rtl/quicksort_engine.sv -----
// Quicksort engine: collects a set of signed values, sorts them and streams them out.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): one element per request,
// the final element of a set marked with is_last. Loading takes one request per
// cycle. Up to DEPTH elements are kept; further ones are discarded and the set's
// overflow flag is raised, but a discarded is_last still closes the set.
// After is_last the engine stops taking requests and sorts in place (Hoare
// partition, middle pivot, explicit range stack). Sort time is data dependent,
// bounded by the single read port of the element RAM.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): the sorted set, one
// request per cycle while the receiver is ready, last_out on the final one,
// each carrying the comparison and swap counts of this sort and the overflow
// flag. The output register holds while the receiver stalls; once the final
// result sits in it, the next set can be loaded.
// Reset clears the fill count, stack pointer, counters and flags; the RAMs are
// not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
module quicksort_engine #(
  parameter int DEPTH = qsort_pkg::QS_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qsort_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qsort_pkg::out_rsp_t out_rsp_o
);
  import qsort_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qsort_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_req_i.is_last),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  qsort_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
